[hdl/spc_pkg.sv]
// Shared types and constants of the 2D shape pair collision test.
`default_nettype none
package spc_pkg;

  // Field widths and fixed-point scaling
  localparam int COORD_BITS_DEF = 16;
  localparam int KIND_W         = 4;
  localparam int HALF_W         = 15;
  localparam int ROT_W          = 16;
  localparam int FRAC_SHIFT     = 14;
  localparam int RAD_SHIFT      = 2 * FRAC_SHIFT;
  localparam int AXES           = 4;
  localparam int QDEPTH         = 2;

  // Unit rotation in Q1.14
  localparam logic signed [ROT_W-1:0] ONE_Q14 = 16'sd16384;

  // Shape codes
  localparam logic [1:0] SHAPE_AABB   = 2'd0;
  localparam logic [1:0] SHAPE_CIRCLE = 2'd1;
  localparam logic [1:0] SHAPE_OBB    = 2'd2;

  // Test class chosen by the front end
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_CC,
    CLS_CB,
    CLS_BB
  } cls_t;

  // Classified request; for circle-box the circle is in slot a, the box in slot b
  typedef struct packed {
    cls_t                     cls;
    logic signed [ROT_W-1:0]  a_cos;
    logic signed [ROT_W-1:0]  a_sin;
    logic signed [ROT_W-1:0]  b_cos;
    logic signed [ROT_W-1:0]  b_sin;
    logic        [HALF_W-1:0] a_hx;
    logic        [HALF_W-1:0] a_hy;
    logic        [HALF_W-1:0] b_hx;
    logic        [HALF_W-1:0] b_hy;
  } item_t;

endpackage
`default_nettype wire

[hdl/spc_front.sv]
// Front end: decodes the shape pair code and builds the classified request.
`default_nettype none
module spc_front #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  wire logic        [spc_pkg::KIND_W-1:0] kind,
  input  wire logic signed [COORD_BITS-1:0]      a_center_x,
  input  wire logic signed [COORD_BITS-1:0]      a_center_y,
  input  wire logic        [spc_pkg::HALF_W-1:0] a_half_x,
  input  wire logic        [spc_pkg::HALF_W-1:0] a_half_y,
  input  wire logic        [2*spc_pkg::ROT_W-1:0] a_rotation,
  input  wire logic signed [COORD_BITS-1:0]      b_center_x,
  input  wire logic signed [COORD_BITS-1:0]      b_center_y,
  input  wire logic        [spc_pkg::HALF_W-1:0] b_half_x,
  input  wire logic        [spc_pkg::HALF_W-1:0] b_half_y,
  input  wire logic        [2*spc_pkg::ROT_W-1:0] b_rotation,
  output spc_pkg::item_t                         item,
  output logic signed      [COORD_BITS:0]        dx,
  output logic signed      [COORD_BITS:0]        dy
);

  localparam int RW = spc_pkg::ROT_W;

  logic [1:0] ka;
  logic [1:0] kb;
  logic       legal;
  logic       swap;
  logic signed [RW-1:0] ac, as_v, bc, bs_v;

  // Split pair code into the two shape codes
  always_comb begin
    legal = 1'b1;
    ka    = spc_pkg::SHAPE_AABB;
    kb    = spc_pkg::SHAPE_AABB;
    case (kind)
      4'd0: begin ka = spc_pkg::SHAPE_AABB;   kb = spc_pkg::SHAPE_AABB;   end
      4'd1: begin ka = spc_pkg::SHAPE_AABB;   kb = spc_pkg::SHAPE_CIRCLE; end
      4'd2: begin ka = spc_pkg::SHAPE_AABB;   kb = spc_pkg::SHAPE_OBB;    end
      4'd3: begin ka = spc_pkg::SHAPE_CIRCLE; kb = spc_pkg::SHAPE_AABB;   end
      4'd4: begin ka = spc_pkg::SHAPE_CIRCLE; kb = spc_pkg::SHAPE_CIRCLE; end
      4'd5: begin ka = spc_pkg::SHAPE_CIRCLE; kb = spc_pkg::SHAPE_OBB;    end
      4'd6: begin ka = spc_pkg::SHAPE_OBB;    kb = spc_pkg::SHAPE_AABB;   end
      4'd7: begin ka = spc_pkg::SHAPE_OBB;    kb = spc_pkg::SHAPE_CIRCLE; end
      4'd8: begin ka = spc_pkg::SHAPE_OBB;    kb = spc_pkg::SHAPE_OBB;    end
      default: legal = 1'b0;
    endcase
  end

  // Rotation; identity unless oriented box
  always_comb begin
    ac   = (ka == spc_pkg::SHAPE_OBB) ? $signed(a_rotation[RW-1:0])    : spc_pkg::ONE_Q14;
    as_v = (ka == spc_pkg::SHAPE_OBB) ? $signed(a_rotation[2*RW-1:RW]) : '0;
    bc   = (kb == spc_pkg::SHAPE_OBB) ? $signed(b_rotation[RW-1:0])    : spc_pkg::ONE_Q14;
    bs_v = (kb == spc_pkg::SHAPE_OBB) ? $signed(b_rotation[2*RW-1:RW]) : '0;
  end

  // Classify; the circle of a circle-box pair always goes to slot a
  always_comb begin
    swap = (kb == spc_pkg::SHAPE_CIRCLE) && (ka != spc_pkg::SHAPE_CIRCLE);
    if (!legal) begin
      item.cls = spc_pkg::CLS_NONE;
    end else if (ka == spc_pkg::SHAPE_CIRCLE && kb == spc_pkg::SHAPE_CIRCLE) begin
      item.cls = spc_pkg::CLS_CC;
    end else if (ka == spc_pkg::SHAPE_CIRCLE || kb == spc_pkg::SHAPE_CIRCLE) begin
      item.cls = spc_pkg::CLS_CB;
    end else begin
      item.cls = spc_pkg::CLS_BB;
    end
    if (swap) begin
      item.a_cos = bc;   item.a_sin = bs_v; item.a_hx = b_half_x; item.a_hy = b_half_y;
      item.b_cos = ac;   item.b_sin = as_v; item.b_hx = a_half_x; item.b_hy = a_half_y;
    end else begin
      item.a_cos = ac;   item.a_sin = as_v; item.a_hx = a_half_x; item.a_hy = a_half_y;
      item.b_cos = bc;   item.b_sin = bs_v; item.b_hx = b_half_x; item.b_hy = b_half_y;
    end
  end

  // Center difference; only its magnitude matters for circle tests
  assign dx = (COORD_BITS+1)'(b_center_x) - (COORD_BITS+1)'(a_center_x);
  assign dy = (COORD_BITS+1)'(b_center_y) - (COORD_BITS+1)'(a_center_y);

endmodule
`default_nettype wire

[hdl/spc_queue.sv]
// Short request queue between front end and back end.
`default_nettype none
module spc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = spc_pkg::QDEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/spc_back.sv]
// Back end: five-stage pipeline evaluating the overlap tests.
`default_nettype none
module spc_back #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  input  wire spc_pkg::item_t                 item,
  input  wire logic signed [COORD_BITS:0]     dx,
  input  wire logic signed [COORD_BITS:0]     dy,
  output logic                                req_take,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                hit
);

  localparam int AX   = spc_pkg::AXES;
  localparam int HW   = spc_pkg::HALF_W;
  localparam int DW   = COORD_BITS + 1;
  localparam int AW   = spc_pkg::ROT_W + 1;
  localparam int PW   = DW + AW;
  localparam int SW   = PW + 1;
  localparam int RPW  = spc_pkg::ROT_W + AW;
  localparam int RSW  = RPW + 1;
  localparam int EPW  = RSW + HW;
  localparam int EW   = EPW + 1;
  localparam int TW   = EW + 1;
  localparam int BXW  = HW + spc_pkg::FRAC_SHIFT;
  localparam int QW   = (SW > BXW) ? SW : BXW;
  localparam int SQW  = 2 * QW;
  localparam int LW   = SQW + 1;
  localparam int RRW  = 2 * (HW + 1);
  localparam int CW   = (LW > RRW + spc_pkg::RAD_SHIFT) ? LW : RRW + spc_pkg::RAD_SHIFT;
  localparam int BW   = (SW + spc_pkg::FRAC_SHIFT > TW) ? SW + spc_pkg::FRAC_SHIFT : TW;

  logic en;
  logic va, vb, vc, vd;

  assign en       = !out_valid || !out_stall;
  assign req_take = en && req_valid;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      va <= req_valid; vb <= va; vc <= vb; vd <= vc; out_valid <= vd;
    end
  end

  // ---------------- Stage A: axis products ----------------
  logic signed [AW-1:0]  ax [AX];
  logic signed [AW-1:0]  ay [AX];
  logic signed [PW-1:0]  pd0_c [AX], pd1_c [AX];
  logic signed [RPW-1:0] au0_c [AX], au1_c [AX], av0_c [AX], av1_c [AX];
  logic signed [RPW-1:0] bu0_c [AX], bu1_c [AX], bv0_c [AX], bv1_c [AX];

  logic signed [PW-1:0]  a_pd0 [AX], a_pd1 [AX];
  logic signed [RPW-1:0] a_au0 [AX], a_au1 [AX], a_av0 [AX], a_av1 [AX];
  logic signed [RPW-1:0] a_bu0 [AX], a_bu1 [AX], a_bv0 [AX], a_bv1 [AX];
  spc_pkg::item_t        a_item;
  logic signed [DW-1:0]  a_dx, a_dy;

  // Axes: both axes of box a, then both axes of box b
  always_comb begin
    ax[0] = AW'(item.a_cos);   ay[0] = AW'(item.a_sin);
    ax[1] = -AW'(item.a_sin);  ay[1] = AW'(item.a_cos);
    ax[2] = AW'(item.b_cos);   ay[2] = AW'(item.b_sin);
    ax[3] = -AW'(item.b_sin);  ay[3] = AW'(item.b_cos);
    for (int i = 0; i < AX; i++) begin
      pd0_c[i] = PW'(dx) * PW'(ax[i]);
      pd1_c[i] = PW'(dy) * PW'(ay[i]);
      au0_c[i] = RPW'(item.a_cos) * RPW'(ax[i]);
      au1_c[i] = RPW'(item.a_sin) * RPW'(ay[i]);
      av0_c[i] = RPW'(item.a_sin) * RPW'(ax[i]);
      av1_c[i] = RPW'(item.a_cos) * RPW'(ay[i]);
      bu0_c[i] = RPW'(item.b_cos) * RPW'(ax[i]);
      bu1_c[i] = RPW'(item.b_sin) * RPW'(ay[i]);
      bv0_c[i] = RPW'(item.b_sin) * RPW'(ax[i]);
      bv1_c[i] = RPW'(item.b_cos) * RPW'(ay[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= item;
      a_dx   <= dx;
      a_dy   <= dy;
      for (int i = 0; i < AX; i++) begin
        a_pd0[i] <= pd0_c[i]; a_pd1[i] <= pd1_c[i];
        a_au0[i] <= au0_c[i]; a_au1[i] <= au1_c[i];
        a_av0[i] <= av0_c[i]; a_av1[i] <= av1_c[i];
        a_bu0[i] <= bu0_c[i]; a_bu1[i] <= bu1_c[i];
        a_bv0[i] <= bv0_c[i]; a_bv1[i] <= bv1_c[i];
      end
    end
  end

  // ---------------- Stage B: projections and magnitudes ----------------
  logic signed [SW-1:0]  sd_c [AX];
  logic signed [RSW-1:0] sau_c [AX], sav_c [AX], sbu_c [AX], sbv_c [AX];
  logic        [SW-1:0]  dist_c [AX];
  logic        [RSW-1:0] pau_c [AX], pav_c [AX], pbu_c [AX], pbv_c [AX];
  logic        [DW-1:0]  dxm_c, dym_c;
  logic        [HW:0]    rsum_c;

  logic        [SW-1:0]  b_dist [AX];
  logic        [RSW-1:0] b_pau [AX], b_pav [AX], b_pbu [AX], b_pbv [AX];
  logic        [DW-1:0]  b_dxm, b_dym;
  logic        [HW:0]    b_rsum;
  spc_pkg::item_t        b_item;

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      sd_c[i]   = SW'(a_pd0[i]) + SW'(a_pd1[i]);
      sau_c[i]  = RSW'(a_au0[i]) + RSW'(a_au1[i]);
      sav_c[i]  = RSW'(a_av1[i]) - RSW'(a_av0[i]);
      sbu_c[i]  = RSW'(a_bu0[i]) + RSW'(a_bu1[i]);
      sbv_c[i]  = RSW'(a_bv1[i]) - RSW'(a_bv0[i]);
      dist_c[i] = sd_c[i][SW-1]   ? SW'(-sd_c[i])   : SW'(sd_c[i]);
      pau_c[i]  = sau_c[i][RSW-1] ? RSW'(-sau_c[i]) : RSW'(sau_c[i]);
      pav_c[i]  = sav_c[i][RSW-1] ? RSW'(-sav_c[i]) : RSW'(sav_c[i]);
      pbu_c[i]  = sbu_c[i][RSW-1] ? RSW'(-sbu_c[i]) : RSW'(sbu_c[i]);
      pbv_c[i]  = sbv_c[i][RSW-1] ? RSW'(-sbv_c[i]) : RSW'(sbv_c[i]);
    end
    dxm_c  = a_dx[DW-1] ? DW'(-a_dx) : DW'(a_dx);
    dym_c  = a_dy[DW-1] ? DW'(-a_dy) : DW'(a_dy);
    // Circle pair uses the radius sum, circle-box the circle radius alone
    rsum_c = (a_item.cls == spc_pkg::CLS_CC) ?
             ({1'b0, a_item.a_hx} + {1'b0, a_item.b_hx}) : {1'b0, a_item.a_hx};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_item <= a_item;
      b_dxm  <= dxm_c;
      b_dym  <= dym_c;
      b_rsum <= rsum_c;
      for (int i = 0; i < AX; i++) begin
        b_dist[i] <= dist_c[i];
        b_pau[i]  <= pau_c[i]; b_pav[i] <= pav_c[i];
        b_pbu[i]  <= pbu_c[i]; b_pbv[i] <= pbv_c[i];
      end
    end
  end

  // ---------------- Stage C: extents and corner clamp ----------------
  logic [EW-1:0] ea_c [AX], eb_c [AX];
  logic [QW-1:0] bx_c, by_c, lx_c, ly_c, qx_c, qy_c;

  logic [EW-1:0] c_ea [AX], c_eb [AX];
  logic [QW-1:0] c_qx, c_qy;
  logic [SW-1:0] c_dist [AX];
  logic [DW-1:0] c_dxm, c_dym;
  logic [HW:0]   c_rsum;
  spc_pkg::cls_t c_cls;

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      ea_c[i] = EW'(b_pau[i]) * EW'(b_item.a_hx) + EW'(b_pav[i]) * EW'(b_item.a_hy);
      eb_c[i] = EW'(b_pbu[i]) * EW'(b_item.b_hx) + EW'(b_pbv[i]) * EW'(b_item.b_hy);
    end
    // Box axes of slot b give the circle center in box space
    bx_c = QW'({b_item.b_hx, {spc_pkg::FRAC_SHIFT{1'b0}}});
    by_c = QW'({b_item.b_hy, {spc_pkg::FRAC_SHIFT{1'b0}}});
    lx_c = QW'(b_dist[2]);
    ly_c = QW'(b_dist[3]);
    qx_c = (lx_c > bx_c) ? lx_c - bx_c : '0;
    qy_c = (ly_c > by_c) ? ly_c - by_c : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_cls  <= b_item.cls;
      c_qx   <= qx_c;
      c_qy   <= qy_c;
      c_dxm  <= b_dxm;
      c_dym  <= b_dym;
      c_rsum <= b_rsum;
      for (int i = 0; i < AX; i++) begin
        c_ea[i]   <= ea_c[i];
        c_eb[i]   <= eb_c[i];
        c_dist[i] <= b_dist[i];
      end
    end
  end

  // ---------------- Stage D: squares and extent sums ----------------
  logic [QW-1:0]  mx_c, my_c;
  logic [SQW-1:0] d_sqx, d_sqy;
  logic [RRW-1:0] d_rr;
  logic [TW-1:0]  d_et [AX];
  logic [SW-1:0]  d_dist [AX];
  spc_pkg::cls_t  d_cls;

  always_comb begin
    mx_c = (c_cls == spc_pkg::CLS_CC) ? QW'(c_dxm) : c_qx;
    my_c = (c_cls == spc_pkg::CLS_CC) ? QW'(c_dym) : c_qy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_cls <= c_cls;
      d_sqx <= SQW'(mx_c) * SQW'(mx_c);
      d_sqy <= SQW'(my_c) * SQW'(my_c);
      d_rr  <= RRW'(c_rsum) * RRW'(c_rsum);
      for (int i = 0; i < AX; i++) begin
        d_et[i]   <= TW'(c_ea[i]) + TW'(c_eb[i]);
        d_dist[i] <= c_dist[i];
      end
    end
  end

  // ---------------- Stage E: compares into the output register ----------------
  logic [CW-1:0] lhs_c;
  logic [CW-1:0] rr_c;
  logic          bb_ok_c;
  logic          hit_c;

  always_comb begin
    lhs_c   = CW'(LW'(d_sqx) + LW'(d_sqy));
    rr_c    = CW'(d_rr);
    bb_ok_c = 1'b1;
    for (int i = 0; i < AX; i++) begin
      if ((BW'(d_dist[i]) << spc_pkg::FRAC_SHIFT) > BW'(d_et[i])) begin
        bb_ok_c = 1'b0;
      end
    end
    case (d_cls)
      spc_pkg::CLS_CC: hit_c = (lhs_c <= rr_c);
      spc_pkg::CLS_CB: hit_c = (lhs_c < (rr_c << spc_pkg::RAD_SHIFT));
      spc_pkg::CLS_BB: hit_c = bb_ok_c;
      default:         hit_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_c;
    end
  end

endmodule
`default_nettype wire

[hdl/shape_pair_collision_test_2d_top.sv]
// Top level of the 2D shape pair collision test.
//
// Input channel: in_valid / in_stall with one shape pair per request
// (kind, centers, half widths or radii, rotations). Output channel:
// out_valid / out_stall with one hit bit per request, in request order.
// A request is taken when valid is high and stall is low at a clock edge.
// Throughput: one request per cycle while out_stall is low. An accepted
// request is stored in the two-entry request queue, then passes four
// pipeline registers (axis products, projections, extents/clamp, squares)
// with the compare landing in the output register.
// When the receiver stalls, the pipeline holds its contents and the queue
// fills; in_stall rises once the queue is full and falls as soon as the
// output drains. Synchronous reset (rst) empties the queue and clears all
// valid flags; no result is presented until new requests arrive.
// Kind codes above eight give hit = 0.
`default_nettype none
module shape_pair_collision_test_2d_top #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic        [spc_pkg::KIND_W-1:0] kind,
  input  wire logic signed [COORD_BITS-1:0]      a_center_x,
  input  wire logic signed [COORD_BITS-1:0]      a_center_y,
  input  wire logic        [spc_pkg::HALF_W-1:0] a_half_x,
  input  wire logic        [spc_pkg::HALF_W-1:0] a_half_y,
  input  wire logic        [2*spc_pkg::ROT_W-1:0] a_rotation,
  input  wire logic signed [COORD_BITS-1:0]      b_center_x,
  input  wire logic signed [COORD_BITS-1:0]      b_center_y,
  input  wire logic        [spc_pkg::HALF_W-1:0] b_half_x,
  input  wire logic        [spc_pkg::HALF_W-1:0] b_half_y,
  input  wire logic        [2*spc_pkg::ROT_W-1:0] b_rotation,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  hit
);

  localparam int DW   = COORD_BITS + 1;
  localparam int IW   = $bits(spc_pkg::item_t);
  localparam int QWID = IW + 2 * DW;

  spc_pkg::item_t       f_item;
  logic signed [DW-1:0] f_dx, f_dy;
  logic [QWID-1:0]      q_wdata, q_rdata;
  logic                 q_full, q_not_empty, q_pop;
  spc_pkg::item_t       q_item;
  logic signed [DW-1:0] q_dx, q_dy;

  spc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .kind       (kind),
    .a_center_x (a_center_x),
    .a_center_y (a_center_y),
    .a_half_x   (a_half_x),
    .a_half_y   (a_half_y),
    .a_rotation (a_rotation),
    .b_center_x (b_center_x),
    .b_center_y (b_center_y),
    .b_half_x   (b_half_x),
    .b_half_y   (b_half_y),
    .b_rotation (b_rotation),
    .item       (f_item),
    .dx         (f_dx),
    .dy         (f_dy)
  );

  // Pack classified request for the queue
  assign q_wdata  = {f_item, f_dx, f_dy};
  assign in_stall = q_full;

  spc_queue #(.WIDTH(QWID), .DEPTH(spc_pkg::QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign q_item = spc_pkg::item_t'(q_rdata[QWID-1 -: IW]);
  assign q_dx   = $signed(q_rdata[2*DW-1 -: DW]);
  assign q_dy   = $signed(q_rdata[DW-1:0]);

  spc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (q_not_empty),
    .item      (q_item),
    .dx        (q_dx),
    .dy        (q_dy),
    .req_take  (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the 2D shape pair collision test.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int CB = spc_pkg::COORD_BITS_DEF;
  localparam int HW = spc_pkg::HALF_W;
  localparam logic [3:0] K_AA = 4'd0, K_AC = 4'd1, K_AO = 4'd2, K_CA = 4'd3, K_CC = 4'd4,
                         K_CO = 4'd5, K_OA = 4'd6, K_OC = 4'd7, K_OO = 4'd8, K_BAD = 4'd15;
  localparam logic [31:0] ROT_ID = 32'h0000_4000;
  localparam logic [31:0] ROT_90 = 32'h4000_0000;
  localparam logic [31:0] ROT_45 = 32'h2D41_2D41;
  localparam int NRAND = 1130;

  typedef struct {
    logic [3:0] kind;
    logic signed [CB-1:0] acx, acy, bcx, bcy;
    logic [HW-1:0] ahx, ahy, bhx, bhy;
    logic [31:0] arot, brot;
  } pair_t;

  // Directed row: request plus optional hand-typed result checked against the predictor (-1 = none)
  typedef struct {
    pair_t p;
    int    want;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, hit;
  pair_t drv;
  logic expected_hits[$];
  int   errors;
  int   send_idle, recv_idle;

  shape_pair_collision_test_2d_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(drv.kind), .a_center_x(drv.acx), .a_center_y(drv.acy),
    .a_half_x(drv.ahx), .a_half_y(drv.ahy), .a_rotation(drv.arot),
    .b_center_x(drv.bcx), .b_center_y(drv.bcy), .b_half_x(drv.bhx),
    .b_half_y(drv.bhy), .b_rotation(drv.brot),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shape in the predictor's terms: centers, sizes and axis (cos, sin)
  typedef struct {
    longint cx, cy, hx, hy, c, s;
  } shp_t;

  function automatic shp_t load_shape(logic [1:0] k, logic signed [CB-1:0] x,
                                      logic signed [CB-1:0] y, logic [HW-1:0] hx,
                                      logic [HW-1:0] hy, logic [31:0] rot);
    shp_t sh;
    sh.cx = x; sh.cy = y; sh.hx = hx; sh.hy = hy;
    if (k == spc_pkg::SHAPE_OBB) begin
      sh.c = $signed(rot[15:0]);
      sh.s = $signed(rot[31:16]);
    end else begin
      sh.c = spc_pkg::ONE_Q14;
      sh.s = 0;
    end
    return sh;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [127:0] extent(shp_t b, longint ax, longint ay);
    logic [127:0] pu, pv;
    pu = absv(b.c * ax + b.s * ay);
    pv = absv(-b.s * ax + b.c * ay);
    return pu * b.hx + pv * b.hy;
  endfunction

  function automatic bit axis_ok(shp_t a, shp_t b, longint ax, longint ay);
    logic [127:0] proj;
    proj = absv((b.cx - a.cx) * ax + (b.cy - a.cy) * ay);
    proj = proj << 14;
    return proj <= extent(a, ax, ay) + extent(b, ax, ay);
  endfunction

  function automatic bit circle_vs_box(shp_t cir, shp_t bx);
    longint dx, dy;
    logic [127:0] lx, ly, ex, ey, qx, qy, r;
    dx = cir.cx - bx.cx;
    dy = cir.cy - bx.cy;
    lx = absv(bx.c * dx + bx.s * dy);
    ly = absv(-bx.s * dx + bx.c * dy);
    ex = 128'(bx.hx) << 14;
    ey = 128'(bx.hy) << 14;
    qx = lx > ex ? lx - ex : 0;
    qy = ly > ey ? ly - ey : 0;
    r = 128'(cir.hx) * cir.hx;
    return qx * qx + qy * qy < (r << 28);
  endfunction

  function automatic bit predict_hit(pair_t p);
    shp_t a, b;
    logic [1:0] ka, kb;
    logic [127:0] dx, dy, r;
    if (p.kind > K_OO) return 1'b0;
    ka = 2'(p.kind / 3);
    kb = 2'(p.kind % 3);
    a = load_shape(ka, p.acx, p.acy, p.ahx, p.ahy, p.arot);
    b = load_shape(kb, p.bcx, p.bcy, p.bhx, p.bhy, p.brot);
    if (ka == spc_pkg::SHAPE_CIRCLE && kb == spc_pkg::SHAPE_CIRCLE) begin
      dx = absv(a.cx - b.cx);
      dy = absv(a.cy - b.cy);
      r = a.hx + b.hx;
      return dx * dx + dy * dy <= r * r;
    end
    if (ka == spc_pkg::SHAPE_CIRCLE) return circle_vs_box(a, b);
    if (kb == spc_pkg::SHAPE_CIRCLE) return circle_vs_box(b, a);
    return axis_ok(a, b, a.c, a.s) && axis_ok(a, b, -a.s, a.c) &&
           axis_ok(a, b, b.c, b.s) && axis_ok(a, b, -b.s, b.c);
  endfunction

  function automatic pair_t mk(logic [3:0] k, int acx, int acy, int ahx, int ahy,
                               logic [31:0] ar, int bcx, int bcy, int bhx, int bhy,
                               logic [31:0] br);
    pair_t p;
    p.kind = k; p.acx = CB'(acx); p.acy = CB'(acy); p.ahx = HW'(ahx); p.ahy = HW'(ahy);
    p.arot = ar;
    p.bcx = CB'(bcx); p.bcy = CB'(bcy); p.bhx = HW'(bhx); p.bhy = HW'(bhy); p.brot = br;
    return p;
  endfunction

  // Random rotation: half the time a fixed unit angle, else random components or raw bits
  function automatic logic [31:0] rand_rot();
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: return $urandom;
      1: return ROT_ID;
      2: return ROT_90;
      3: return ROT_45;
      default: begin
        int c, s;
        c = $urandom_range(0, 32768) - 16384;
        s = $urandom_range(0, 32768) - 16384;
        return {s[15:0], c[15:0]};
      end
    endcase
  endfunction

  // Random pair: usually clustered so hits and misses both occur
  function automatic pair_t rand_pair();
    pair_t p;
    int span;
    p.kind = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
    if ($urandom_range(0, 7) == 0) begin
      p.acx = CB'($urandom); p.acy = CB'($urandom);
      p.bcx = CB'($urandom); p.bcy = CB'($urandom);
      p.ahx = HW'($urandom); p.ahy = HW'($urandom);
      p.bhx = HW'($urandom); p.bhy = HW'($urandom);
    end else begin
      span = 1 << $urandom_range(4, 13);
      p.acx = CB'($urandom_range(0, 65535) - 32768);
      p.acy = CB'($urandom_range(0, 65535) - 32768);
      p.bcx = CB'(p.acx + $urandom_range(0, 2 * span) - span);
      p.bcy = CB'(p.acy + $urandom_range(0, 2 * span) - span);
      p.ahx = HW'($urandom_range(0, span / 2)); p.ahy = HW'($urandom_range(0, span / 2));
      p.bhx = HW'($urandom_range(0, span / 2)); p.bhy = HW'($urandom_range(0, span / 2));
    end
    p.arot = rand_rot();
    p.brot = rand_rot();
    return p;
  endfunction

  // Present one request and wait until in_stall is seen low
  task automatic send_request(pair_t p);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    drv <= p;
    in_valid <= 1'b1;
    expected_hits.push_back(predict_hit(p));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (recv_idle > 0) && ($urandom_range(0, 99) < recv_idle);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $error("hit: unexpected result %0b", hit);
        errors++;
      end else begin
        logic e;
        e = expected_hits.pop_front();
        if (hit !== e) begin
          $error("hit: expected %0b actual %0b", e, hit);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t rows[$];
    int phase;
    logic expected;
    errors = 0;
    send_idle = 34;
    recv_idle = 55;
    rst = 1'b1;
    in_valid = 1'b0;
    drv = mk(K_AA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every pair code, touching edges, bad kinds
    rows.push_back('{mk(K_AA, 0, 0, 16, 16, 0, 32, 0, 16, 16, 0), 1});
    rows.push_back('{mk(K_AA, 0, 0, 16, 16, 0, 33, 0, 16, 16, 0), 0});
    rows.push_back('{mk(K_AA, -32768, -32768, 0, 0, '1, 32767, 32767, 0, 0, '1), 0});
    rows.push_back('{mk(K_AA, -32768, -32768, 32767, 32767, 0, 32767, 32767, 32767, 32767,
                        0), 0});
    rows.push_back('{mk(K_AA, 5, 5, 0, 0, 0, 5, 5, 0, 0, 0), 1});
    rows.push_back('{mk(K_CC, 0, 0, 30, 0, 0, 30, 40, 20, 0, 0), 1});
    rows.push_back('{mk(K_CC, 0, 0, 30, 0, 0, 30, 41, 20, 0, 0), 0});
    rows.push_back('{mk(K_CC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1});
    rows.push_back('{mk(K_CA, 0, 0, 16, '1, '1, 32, 0, 16, 16, 0), 0});
    rows.push_back('{mk(K_CA, 0, 0, 17, 0, 0, 32, 0, 16, 16, 0), 1});
    rows.push_back('{mk(K_AC, 0, 0, 16, 16, 0, 0, 0, 0, 0, 0), 0});
    rows.push_back('{mk(K_AC, 0, 0, 16, 16, 0, 0, 0, 1, 0, 0), 1});
    rows.push_back('{mk(K_CO, 0, 0, 20, 0, 0, 30, 0, 5, 40, ROT_90), -1});
    rows.push_back('{mk(K_OC, 0, 0, 40, 5, ROT_45, 25, 25, 3, 9, 0), -1});
    rows.push_back('{mk(K_AO, 0, 0, 16, 16, 0, 40, 0, 16, 16, ROT_45), -1});
    rows.push_back('{mk(K_OA, 0, 0, 100, 4, ROT_45, 60, 60, 4, 4, '1), -1});
    rows.push_back('{mk(K_OO, 0, 0, 100, 4, ROT_45, 0, 0, 100, 4, 32'hD2BF_2D41), -1});
    rows.push_back('{mk(K_OO, -32768, 32767, 32767, 32767, 32'h8000_8000, 32767, -32768,
                        32767, 32767, 32'h7FFF_7FFF), -1});
    rows.push_back('{mk(K_OO, 0, 0, 10, 10, 0, 0, 0, 10, 10, 0), 1});
    rows.push_back('{mk(4'd9, 0, 0, 10, 10, 0, 0, 0, 10, 10, 0), 0});
    rows.push_back('{mk(K_BAD, 0, 0, 10, 10, 0, 0, 0, 10, 10, 0), 0});
    foreach (rows[i]) begin
      if (rows[i].want >= 0) begin
        expected = predict_hit(rows[i].p);
        if (expected !== rows[i].want[0]) begin
          $error("hit: table row %0d expected %0d predicted %0b", i, rows[i].want, expected);
          errors++;
        end
      end
      send_request(rows[i].p);
    end

    // Random part in three idling phases, draining between them
    for (phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < NRAND / 3; n++) send_request(rand_pair());
      in_valid <= 1'b0;
      @(posedge clk);
      while (expected_hits.size() != 0) @(posedge clk);
      send_idle = (phase == 0) ? 55 : 0;
      recv_idle = (phase == 0) ? 34 : 0;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
